>>> rtl/wbps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_pkg
// shared constants and types of the wildcard byte pattern search block
// ----------------------------------------------------------------------------
package wbps_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int POS_BITS    = 32;
    localparam int LEN_BITS    = 6;
    localparam int CFG_BITS    = 64;
    localparam int IDX_BITS    = 3;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    // configuration register indexes
    localparam logic [IDX_BITS-1:0] REG_PAT_LOW      = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_PAT_MID_LOW  = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_PAT_MID_HIGH = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_PAT_HIGH     = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_CARE_BITS    = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_PAT_LENGTH   = 3'd5;

    // search status codes
    localparam logic STATUS_FOUND  = 1'b0;
    localparam logic STATUS_ABSENT = 1'b1;

    // pattern aligned to the window: entry j pairs with window byte j (0 newest)
    typedef struct packed {
        logic [MAX_PATTERN-1:0][7:0] pat;
        logic [MAX_PATTERN-1:0]      care;
        logic [LEN_BITS-1:0]         len;
    } t_align;

endpackage
`default_nettype wire

>>> rtl/wbps_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_cfg
// configuration registers and the pattern realigned to window order
// ----------------------------------------------------------------------------
module wbps_cfg import wbps_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [CFG_BITS-1:0] i_cfg_data,
    output t_align                   o_align
);

    logic [3:0][CFG_BITS-1:0] r_pat_regs;
    logic [MAX_PATTERN-1:0]   r_care;
    logic [LEN_BITS-1:0]      r_len;
    t_align                   r_align;
    t_align                   n_align;
    logic [LEN_BITS-1:0]      eff_len;
    logic [7:0]               pat_byte [MAX_PATTERN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_regs <= '0;
            r_care     <= '1;
            r_len      <= LEN_BITS'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PAT_LOW:      r_pat_regs[0] <= i_cfg_data;
                REG_PAT_MID_LOW:  r_pat_regs[1] <= i_cfg_data;
                REG_PAT_MID_HIGH: r_pat_regs[2] <= i_cfg_data;
                REG_PAT_HIGH:     r_pat_regs[3] <= i_cfg_data;
                REG_CARE_BITS:    r_care        <= i_cfg_data[MAX_PATTERN-1:0];
                REG_PAT_LENGTH:   r_len         <= i_cfg_data[LEN_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            pat_byte[i] = r_pat_regs[i / 8][(i % 8) * 8 +: 8];
        end
    end

    // zero length acts as one, oversize length clamps to the store
    always_comb begin
        priority if (r_len == '0) begin
            eff_len = LEN_BITS'(1);
        end else if (r_len > LEN_BITS'(MAX_PATTERN)) begin
            eff_len = LEN_BITS'(MAX_PATTERN);
        end else begin
            eff_len = r_len;
        end
    end

    // window byte j (newest first) faces pattern byte len-1-j
    always_comb begin
        logic [4:0] src;
        n_align.len = eff_len;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            src = 5'(eff_len - LEN_BITS'(1) - LEN_BITS'(j));
            if (LEN_BITS'(j) < eff_len) begin
                n_align.pat[j]  = pat_byte[src];
                n_align.care[j] = r_care[src];
            end else begin
                n_align.pat[j]  = '0;
                n_align.care[j] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align <= '{pat: '0, care: '0, len: LEN_BITS'(1)};
        end else begin
            r_align <= n_align;
        end
    end

    assign o_align = r_align;

endmodule
`default_nettype wire

>>> rtl/wildcard_byte_pattern_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search
// streaming search for a wildcard byte pattern of up to 32 bytes
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one byte of the searched region per transaction, tlast on
//   the region's final byte. m_axis returns at most one result per region:
//   tuser 0 with the match start offset in tdata when the pattern's last byte
//   arrives, or tuser 1 with tdata 0 on the final byte when nothing matched.
//   Bytes after a match are absorbed silently until tlast.
//   Throughput: one byte per cycle while no result stalls on m_axis; the whole
//   window is compared against the realigned pattern in a single stage between
//   the input and result registers.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while no
//   region is in flight; a new pattern applies once the align register holds it.
//   Reset (synchronous, active low) restores the register defaults and starts
//   a new region. When m_axis stalls with a result pending, the input register
//   holds one byte and s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search import wbps_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [CFG_BITS-1:0] i_cfg_data,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [7:0]          s_axis_tdata,   // [7:0] data_byte
    input  wire logic                s_axis_tlast,   // last_byte
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [POS_BITS-1:0]      m_axis_tdata,   // [31:0] match_offset
    output logic                     m_axis_tuser    // search_status
);

    t_align              align;

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_last;

    logic [7:0]          r_win [MAX_PATTERN];
    logic [7:0]          n_win [MAX_PATTERN];
    logic [POS_BITS-1:0] r_seen;
    logic [POS_BITS-1:0] n_seen;
    logic                r_done;

    logic                r_out_valid;
    logic [POS_BITS-1:0] r_out_offset;
    logic                r_out_status;

    logic                proc_go;
    logic                hit;
    logic                found;

    wbps_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_align    (align)
    );

    assign proc_go       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || proc_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // window after shifting in the current byte
    always_comb begin
        n_win[0] = r_in_byte;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            n_win[j] = r_win[j-1];
        end
    end

    assign n_seen = (r_seen == POS_MAX) ? r_seen : r_seen + POS_BITS'(1);

    always_comb begin
        hit = 1'b1;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            if (align.care[j] && (n_win[j] != align.pat[j])) begin
                hit = 1'b0;
            end
        end
    end

    assign found = hit && (n_seen >= POS_BITS'(align.len));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_done <= 1'b0;
            for (int j = 0; j < MAX_PATTERN; j++) begin
                r_win[j] <= '0;
            end
        end else if (proc_go) begin
            if (r_in_last) begin
                r_seen <= '0;
                r_done <= 1'b0;
                for (int j = 0; j < MAX_PATTERN; j++) begin
                    r_win[j] <= '0;
                end
            end else if (!r_done) begin
                r_seen <= n_seen;
                r_done <= found;
                for (int j = 0; j < MAX_PATTERN; j++) begin
                    r_win[j] <= n_win[j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (proc_go && !r_done && (found || r_in_last)) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && !r_done) begin
            if (found) begin
                r_out_status <= STATUS_FOUND;
                r_out_offset <= n_seen - POS_BITS'(align.len);
            end else if (r_in_last) begin
                r_out_status <= STATUS_ABSENT;
                r_out_offset <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_offset;
    assign m_axis_tuser  = r_out_status;

endmodule
`default_nettype wire

>>> rtl/wbps_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_checker
// port-level checks of the wildcard byte pattern search block
// ----------------------------------------------------------------------------
module wbps_checker import wbps_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                s_axis_tvalid,
    input wire logic                s_axis_tready,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [POS_BITS-1:0] m_axis_tdata,
    input wire logic                m_axis_tuser
);

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result pending right after reset");

    // a not-found result carries a zero offset
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == STATUS_ABSENT) |-> (m_axis_tdata == '0))
        else $error("not-found result with nonzero offset");

    // with no result pending the input side never stalls
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while no result is pending");

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
